### rtl/kvm_pkg.sv
package kvm_pkg;

    // operation codes carried in the request
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_SEARCH = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    // config register indexes (word addresses)
    localparam logic REG_EMPTY_VALUE = 1'b0;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 5;
    localparam int ENTRY_W = 1 + KEY_W + VAL_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } kvm_state_t;

    typedef struct packed {
        logic clear;
        logic start;
        logic scan;
        logic commit;
    } kvm_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_end;
        logic out_free;
    } kvm_status_t;

endpackage

### rtl/kvm_ctrl.sv
module kvm_ctrl
    import kvm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  kvm_status_t status,
    output kvm_cmd_t    cmd
);

    kvm_state_t state_reg;
    kvm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_end) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // wait for room in the output register
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

### rtl/kvm_dp.sv
module kvm_dp
    import kvm_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  kvm_cmd_t          cmd,
    output kvm_status_t       status,
    input  logic [71:0]       s_tdata,
    input  logic [VAL_W-1:0]  empty_value,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);

    // entry layout: valid, key, value
    logic [ENTRY_W-1:0] mem [CAPACITY];

    logic [1:0]         func_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   value_reg;

    logic [AW-1:0]      addr_reg;
    logic               issue_done_reg;
    logic               cmp_vld_reg;
    logic [AW-1:0]      cmp_idx_reg;
    logic [ENTRY_W-1:0] rd_data_reg;

    logic               hit_reg;
    logic [AW-1:0]      hit_idx_reg;
    logic [VAL_W-1:0]   hit_value_reg;
    logic               free_found_reg;
    logic [AW-1:0]      free_idx_reg;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               m_tvalid_reg;
    logic [39:0]        m_tdata_reg;

    logic               issue;
    logic               rd_valid;
    logic               rd_match;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               reject;
    logic [VAL_W-1:0]   res_value;

    assign issue    = cmd.scan && !issue_done_reg;
    assign rd_valid = rd_data_reg[ENTRY_W-1];
    assign rd_match = rd_valid && (rd_data_reg[ENTRY_W-2 -: KEY_W] == key_reg);

    assign status.clear_last = (addr_reg == LAST_IDX);
    assign status.scan_end   = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);
    assign status.out_free   = !m_tvalid_reg || m_tready;

    // commit decision
    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = hit_idx_reg;
        wr_data    = {1'b1, key_reg, value_reg};
        reject     = 1'b0;
        count_next = count_reg;
        if (func_reg == FUNC_ADD) begin
            if (hit_reg) begin
                wr_en = 1'b1;
            end else if (free_found_reg && (count_reg < CAP_CNT)) begin
                wr_en      = 1'b1;
                wr_addr    = free_idx_reg;
                count_next = count_reg + CW'(1);
            end else begin
                reject = 1'b1;
            end
        end else if (func_reg == FUNC_REMOVE) begin
            if (hit_reg) begin
                wr_en   = 1'b1;
                wr_data = {1'b0, key_reg, hit_value_reg};
                if (count_reg != '0) begin
                    count_next = count_reg - CW'(1);
                end
            end
        end
        res_value = hit_reg ? hit_value_reg : empty_value;
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            mem[addr_reg] <= '0;
        end else if (cmd.commit && wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            func_reg  <= s_tdata[1:0];
            key_reg   <= s_tdata[33:2];
            value_reg <= s_tdata[65:34];
        end
    end

    // address counter and scan tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg       <= '0;
            issue_done_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            cmp_vld_reg <= issue;
            cmp_idx_reg <= addr_reg;
            if (cmd.start) begin
                addr_reg       <= '0;
                issue_done_reg <= 1'b0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end else begin
                if (cmd.clear && (addr_reg != LAST_IDX)) begin
                    addr_reg <= addr_reg + AW'(1);
                end
                if (issue) begin
                    if (addr_reg == LAST_IDX) begin
                        issue_done_reg <= 1'b1;
                    end else begin
                        addr_reg <= addr_reg + AW'(1);
                    end
                end
                if (cmp_vld_reg) begin
                    if (rd_match && !hit_reg) begin
                        hit_reg       <= 1'b1;
                        hit_idx_reg   <= cmp_idx_reg;
                        hit_value_reg <= rd_data_reg[VAL_W-1:0];
                    end
                    if (!rd_valid && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= cmp_idx_reg;
                    end
                end
            end
        end
    end

    // live count and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tdata_reg <= {(count_next == '0), COUNT_W'(count_next),
                            reject, hit_reg, res_value};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### rtl/key_value_map_table.sv
// channel   direction  handshake             payload
// s_        in         s_tvalid / s_tready   s_tdata: func, key, value
// m_        out        m_tvalid / m_tready   m_tdata: result, flags, count
// apb       in         psel, penable, pwrite register 0 empty_value at 0x0
//
// one request passes through accept, a read of every table slot through the
// single memory read port with registered read data, then a commit.
// after reset the table runs a clearing pass over every slot, s_tready low.
// the result sits in an output register; the next request is accepted while
// it waits, and the commit of that request stalls until the register frees.
module key_value_map_table
    import kvm_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // func [1:0], key [33:2], value [65:34], zero pad
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // result_value [31:0], found [32], full_reject [33],
                                   // entry_count [38:34], is_empty [39]
);

    kvm_cmd_t    cmd;
    kvm_status_t status;

    logic [VAL_W-1:0] empty_value_reg;
    logic             cfg_wr;

    // apb: single register, word address taken from paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_value_reg <= '0;
        end else if (cfg_wr && (paddr[2] == REG_EMPTY_VALUE)) begin
            empty_value_reg <= pwdata;
        end
    end

    // reads of anything but the one register return zero
    assign prdata = (paddr[2] == REG_EMPTY_VALUE) ? empty_value_reg : '0;

    // sequencer: clear pass, accept, scan, commit
    kvm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // table memory, scan compare, live count and result register
    kvm_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .empty_value (empty_value_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

### test/kvm_map_scoreboard.sv
package kvm_map_scoreboard_pkg;
    import kvm_pkg::*;

    localparam int MAP_SLOTS = 16;

    typedef struct {
        logic [31:0] result_value;
        logic        found;
        logic        full_reject;
        logic [4:0]  entry_count;
        logic        is_empty;
    } map_result_t;

    class map_scoreboard;
        logic [31:0] slot_key[MAP_SLOTS];
        logic [31:0] slot_value[MAP_SLOTS];
        bit          slot_live[MAP_SLOTS];
        int unsigned live_count;
        logic [31:0] empty_value;
        map_result_t awaited[$];
        int          errors;

        function new();
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            live_count  = 0;
            empty_value = '0;
            errors      = 0;
        endfunction

        // only the empty value register exists, other indexes are dropped
        function void write_reg(int index, logic [31:0] data);
            if (index == int'(REG_EMPTY_VALUE)) empty_value = data;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // apply one accepted request to the shadow map, queue its result
        function void note_request(logic [1:0] func, logic [31:0] key, logic [31:0] value);
            int          hit_slot;
            int          free_slot;
            map_result_t res;
            hit_slot  = -1;
            free_slot = -1;
            for (int i = 0; i < MAP_SLOTS; i++) begin
                if (hit_slot < 0 && slot_live[i] && slot_key[i] == key) hit_slot = i;
                if (free_slot < 0 && !slot_live[i]) free_slot = i;
            end
            res.found        = (hit_slot >= 0);
            res.result_value = res.found ? slot_value[hit_slot] : empty_value;
            res.full_reject  = 1'b0;
            case (func)
                FUNC_ADD: begin
                    if (res.found) begin
                        slot_value[hit_slot] = value;
                    end else if (free_slot >= 0 && live_count < MAP_SLOTS) begin
                        slot_key[free_slot]   = key;
                        slot_value[free_slot] = value;
                        slot_live[free_slot]  = 1'b1;
                        live_count++;
                    end else begin
                        res.full_reject = 1'b1;
                    end
                end
                FUNC_REMOVE: begin
                    if (res.found) begin
                        slot_live[hit_slot] = 1'b0;
                        if (live_count > 0) live_count--;
                    end
                end
                default: ;
            endcase
            res.entry_count = live_count[4:0];
            res.is_empty    = (live_count == 0);
            awaited.push_back(res);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h, want %h", what, got, want);
            errors++;
        endtask

        task check_result(logic [39:0] data);
            map_result_t want;
            if (awaited.size() == 0) begin
                report("result with no request pending", data[31:0], 'x);
            end else begin
                want = awaited.pop_front();
                if (data[31:0] !== want.result_value)
                    report("result_value", data[31:0], want.result_value);
                if (data[32] !== want.found)
                    report("found", 32'(data[32]), 32'(want.found));
                if (data[33] !== want.full_reject)
                    report("full_reject", 32'(data[33]), 32'(want.full_reject));
                if (data[38:34] !== want.entry_count)
                    report("entry_count", 32'(data[38:34]), 32'(want.entry_count));
                if (data[39] !== want.is_empty)
                    report("is_empty", 32'(data[39]), 32'(want.is_empty));
            end
        endtask
    endclass

endpackage

### test/key_value_map_table_test.sv
module key_value_map_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kvm_pkg::*;
    import kvm_map_scoreboard_pkg::*;

    // the fourth selector value is not an operation, the block treats it as search
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // index 1 has no register behind it
    localparam int REG_UNMAPPED = 1;

    localparam int REQUEST_LATENCY = 19;     // accept, slot scan, commit
    localparam int LONG_HOLD       = 300;    // receiver stall that backs up the block
    localparam int PHASES          = 6;
    localparam int PHASE_REQUESTS  = 205;
    // slowest run: ~1260 requests with the longest sender gaps and receiver stalls, clearing pass, one long hold
    localparam int CYCLE_LIMIT     = 400000;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata  = '0;   // func [1:0], key [33:2], value [65:34], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // result_value [31:0], found [32], full_reject [33],
                                  // entry_count [38:34], is_empty [39]

    map_scoreboard sb = new();

    // pacing knobs for the stimulus and the receiver
    bit sender_quiet   = 1'b0;
    bit receiver_quiet = 1'b0;
    int hold_off_cycles = 0;
    int cycle_count     = 0;

    key_value_map_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("key_value_map_table regression: fail");
            $finish;
        end
    end

    // setup then access phase; the register takes the write when pready is seen
    task automatic apb_write(int index, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(index << 2);
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.write_reg(index, data);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // offer one request, called just after a falling edge; returns on a falling edge once the request is taken
    task automatic send_request(logic [1:0] func, logic [31:0] key, logic [31:0] value);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {6'b0, value, key, func};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(func, key, value);
        @(negedge aclk);
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    // result side: random stalls, quiet stretches, and the one long hold-off
    initial begin
        int stall;
        int served;
        served = 0;
        @(negedge aclk);
        forever begin
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(negedge aclk);
                hold_off_cycles = 0;
            end else begin
                stall = receiver_quiet ? 0 : $urandom_range(0, 6);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_result(m_tdata);
            served++;
            if (served % 50 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
            @(negedge aclk);
        end
    end

    // stimulus
    initial begin
        logic [31:0] phase_empty[PHASES];
        logic [31:0] key_pool[32];
        int          pool_size;
        bit          filling;
        int          roll;
        logic [1:0]  func;
        logic [31:0] key;

        phase_empty[0] = 32'h7fff_ffff;
        phase_empty[1] = 32'h8000_0000;
        phase_empty[2] = 32'hffff_ffff;
        phase_empty[3] = $urandom;
        phase_empty[4] = $urandom;
        phase_empty[5] = 32'h0000_0000;
        filling = 1'b1;

        // reset held low from the start, released on a falling edge
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // a write to a missing register must leave the empty value at zero
        apb_write(REG_UNMAPPED, 32'h5a5a_5a5a);

        // directed: misses on the empty table
        send_request(FUNC_SEARCH, 32'h1234_5678, 32'hdead_beef);
        send_request(FUNC_REMOVE, 32'h1234_5678, 32'h0);
        send_request(FUNC_UNUSED, 32'h0000_0000, 32'hffff_ffff);
        // extreme keys and values
        send_request(FUNC_ADD, 32'h8000_0000, 32'h7fff_ffff);
        send_request(FUNC_ADD, 32'h7fff_ffff, 32'h8000_0000);
        send_request(FUNC_ADD, 32'h0000_0000, 32'hffff_ffff);
        send_request(FUNC_ADD, 32'hffff_ffff, 32'h0000_0000);
        // update returns the old value, search and the unused selector hit
        send_request(FUNC_ADD, 32'h8000_0000, 32'h0000_0001);
        send_request(FUNC_SEARCH, 32'h7fff_ffff, 32'h0);
        send_request(FUNC_UNUSED, 32'hffff_ffff, 32'h1111_1111);
        // remove frees slot 2, so the next insert lands in that hole
        send_request(FUNC_REMOVE, 32'h0000_0000, 32'h0);
        // fill the table to capacity
        for (int k = 1; k <= MAP_SLOTS - 3; k++)
            send_request(FUNC_ADD, 32'(k), ~32'(k));
        // a new key on a full table is rejected, an existing one still updates
        send_request(FUNC_ADD, 32'h55aa_55aa, 32'haa55_aa55);
        send_request(FUNC_ADD, 32'h7fff_ffff, 32'h1234_5678);

        for (int p = 0; p < PHASES; p++) begin
            // registers only change with nothing in flight
            drain_results();
            apb_write(int'(REG_EMPTY_VALUE), phase_empty[p]);

            // a small key pool keeps hits frequent; large pools overfill the table
            pool_size = (p % 2 == 0) ? $urandom_range(18, 28) : $urandom_range(3, 16);
            foreach (key_pool[j]) key_pool[j] = $urandom;
            if (p == 0) begin
                key_pool[0] = 32'h8000_0000;
                key_pool[1] = 32'h7fff_ffff;
                key_pool[2] = 32'h0000_0000;
                key_pool[3] = 32'hffff_ffff;
            end

            for (int i = 0; i < PHASE_REQUESTS; i++) begin
                // alternate fill and drain stretches so the count sweeps 0 to full
                if (i % 40 == 0) filling = ($urandom_range(0, 2) != 0);
                if (i % 50 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
                roll = $urandom_range(0, 99);
                if (filling)
                    func = (roll < 55) ? FUNC_ADD : (roll < 75) ? FUNC_SEARCH :
                           (roll < 95) ? FUNC_REMOVE : FUNC_UNUSED;
                else
                    func = (roll < 20) ? FUNC_ADD : (roll < 40) ? FUNC_SEARCH :
                           (roll < 95) ? FUNC_REMOVE : FUNC_UNUSED;
                // occasional stray key, mostly a miss
                key = ($urandom_range(0, 9) == 0) ? $urandom
                                                  : key_pool[$urandom_range(0, pool_size - 1)];
                // receiver stalls long while requests keep coming, backs up the input
                if (p == 1 && i == 60) hold_off_cycles = LONG_HOLD;
                // sender pause until every result is back
                if (p == 2 && i == 100) drain_results();
                send_request(func, key, $urandom);
            end
        end

        drain_results();
        repeat (REQUEST_LATENCY + 5) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("key_value_map_table regression: pass");
        else
            $display("key_value_map_table regression: fail");
        $finish;
    end

endmodule
